// File: hw/rtl/rc_channel_classifier_macros.svh
// Assertion macros shared by the classifier checker.
// No dependencies; include by bare file name.
`ifndef RC_CHANNEL_CLASSIFIER_MACROS_SVH
`define RC_CHANNEL_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcc assertion failed");

`endif

// File: hw/rtl/rcc_pkg.sv
// Types, codes and constants of the RC channel classifier.
// No dependencies.
`timescale 1ns / 1ps

package rcc_pkg;

  localparam int unsigned NumChannels = 10;
  localparam int unsigned ChW         = 4;
  localparam int unsigned ValW        = 12;
  localparam int unsigned ModeW       = 3;
  localparam int unsigned ModeMapW    = ModeW * NumChannels;
  localparam int unsigned DeadBandW   = 8;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 30;

  localparam logic [ModeMapW-1:0]  ModeMapReset  = ModeMapW'(481743497);
  localparam logic [DeadBandW-1:0] DeadBandReset = DeadBandW'(30);

  localparam logic [ValW-1:0] ValCenter    = ValW'(1500);
  localparam logic [ValW-1:0] ValLevelMin  = ValW'(1000);
  localparam logic [ValW-1:0] ValLevelNull = ValW'(1050);
  localparam logic [ValW-1:0] ValLevelLow  = ValW'(1150);
  localparam logic [ValW-1:0] ValLevelMax  = ValW'(2000);
  localparam logic [ValW-1:0] ValSwitchLo  = ValW'(1300);
  localparam logic [ValW-1:0] ValSwitchHi  = ValW'(1600);

  typedef enum logic [ModeW-1:0] {
    MODE_NONE     = 3'd0,
    MODE_DEADBAND = 3'd1,
    MODE_LEVEL    = 3'd2,
    MODE_TOGGLE   = 3'd3,
    MODE_PUSH     = 3'd4,
    MODE_SWITCH   = 3'd5
  } mode_e;

  localparam logic [1:0] LevelUnset = 2'd0;
  localparam logic [1:0] LevelNull  = 2'd1;
  localparam logic [1:0] LevelLow   = 2'd2;
  localparam logic [1:0] LevelHigh  = 2'd3;

  localparam logic [1:0] SwPos1  = 2'd0;
  localparam logic [1:0] SwPos2  = 2'd1;
  localparam logic [1:0] SwPos3  = 2'd2;
  localparam logic [1:0] SwError = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgModeMap  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgDeadBand = CfgIdxW'(1);

  typedef struct packed {
    logic [ChW-1:0]  channel;
    logic [ValW-1:0] pulse_value;
  } in_word_t;

  typedef struct packed {
    logic [ChW-1:0]   channel_out;
    logic [ValW-1:0]  value_out;
    logic [ModeW-1:0] mode_used;
    logic [1:0]       throttle_level;
    logic [1:0]       switch_position;
    logic             toggle_on;
    logic             push_event;
  } res_word_t;

  typedef struct packed {
    logic [ModeMapW-1:0]  mode_map;
    logic [DeadBandW-1:0] dead_band;
  } cfg_t;

endpackage

// File: hw/rtl/rcc_cfg_regs.sv
// Configuration registers: mode map and dead band.
// Depends on rcc_pkg.
`timescale 1ns / 1ps

module rcc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rcc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rcc_pkg::CfgDataW-1:0]  cfg_data_i,
  output rcc_pkg::cfg_t                 cfg_o
);
  import rcc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgModeMap:  cfg_d.mode_map  = cfg_data_i[ModeMapW-1:0];
        CfgDeadBand: cfg_d.dead_band = cfg_data_i[DeadBandW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_map  <= ModeMapReset;
      cfg_q.dead_band <= DeadBandReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/rcc_classify.sv
// Per-channel state and the classification logic for one word.
// Depends on rcc_pkg.
`timescale 1ns / 1ps

module rcc_classify (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rcc_pkg::cfg_t      cfg_i,
  input  logic               upd_en_i,
  input  rcc_pkg::in_word_t  word_i,
  output rcc_pkg::res_word_t res_o
);
  import rcc_pkg::*;

  logic             pressed_q [NumChannels];
  logic             toggle_q  [NumChannels];
  logic [1:0]       level_q   [NumChannels];
  logic [ModeW-1:0] mode_arr  [NumChannels];

  logic            in_range;
  mode_e           mode;
  logic [ValW-1:0] v;
  logic [ValW-1:0] delta;
  logic            pressed, last_pr, tog_cur, tog_nxt, push;
  logic [1:0]      lvl_cur, lvl_nxt, sw;
  logic            wr_press, wr_toggle, wr_level;

  always_comb begin
    for (int i = 0; i < NumChannels; i++) begin
      mode_arr[i] = cfg_i.mode_map[ModeW*i +: ModeW];
    end
  end

  assign in_range = (word_i.channel < ChW'(NumChannels));
  assign v        = word_i.pulse_value;
  assign pressed  = (v > ValCenter);
  assign delta    = (v > ValCenter) ? (v - ValCenter) : (ValCenter - v);

  always_comb begin
    mode    = MODE_NONE;
    last_pr = 1'b0;
    tog_cur = 1'b0;
    lvl_cur = LevelUnset;
    if (in_range) begin
      // spare codes 6 and 7 act as none
      if (mode_arr[word_i.channel] <= MODE_SWITCH) mode = mode_e'(mode_arr[word_i.channel]);
      last_pr = pressed_q[word_i.channel];
      tog_cur = toggle_q[word_i.channel];
      lvl_cur = level_q[word_i.channel];
    end
  end

  always_comb begin
    res_o             = '0;
    res_o.channel_out = word_i.channel;
    res_o.value_out   = v;
    tog_nxt   = tog_cur;
    lvl_nxt   = lvl_cur;
    sw        = SwPos1;
    push      = 1'b0;
    wr_press  = 1'b0;
    wr_toggle = 1'b0;
    wr_level  = 1'b0;
    case (mode)
      MODE_DEADBAND: begin
        if (delta < {{(ValW-DeadBandW){1'b0}}, cfg_i.dead_band}) res_o.value_out = ValCenter;
      end
      MODE_LEVEL: begin
        wr_level = 1'b1;
        if (v > ValLevelMin && v <= ValLevelNull) lvl_nxt = LevelNull;
        else if (v > ValLevelNull && v <= ValLevelLow) lvl_nxt = LevelLow;
        else if (v > ValLevelLow && v < ValLevelMax) lvl_nxt = LevelHigh;
      end
      MODE_TOGGLE: begin
        wr_press  = 1'b1;
        wr_toggle = 1'b1;
        if (pressed && !last_pr) tog_nxt = ~tog_cur;
      end
      MODE_PUSH: begin
        wr_press = 1'b1;
        push     = pressed && !last_pr;
      end
      MODE_SWITCH: begin
        if (v < ValSwitchLo) sw = SwPos1;
        else if (v > ValSwitchLo && v < ValSwitchHi) sw = SwPos2;
        else if (v > ValSwitchHi) sw = SwPos3;
        else sw = SwError;
      end
      default: ;
    endcase
    if (in_range) begin
      res_o.mode_used       = mode;
      res_o.throttle_level  = lvl_nxt;
      res_o.switch_position = sw;
      res_o.toggle_on       = tog_nxt;
      res_o.push_event      = push;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChannels; i++) begin
        pressed_q[i] <= 1'b0;
        toggle_q[i]  <= 1'b0;
        level_q[i]   <= LevelUnset;
      end
    end else if (upd_en_i && in_range) begin
      if (wr_press)  pressed_q[word_i.channel] <= pressed;
      if (wr_toggle) toggle_q[word_i.channel]  <= tog_nxt;
      if (wr_level)  level_q[word_i.channel]   <= lvl_nxt;
    end
  end

endmodule

// File: hw/rtl/rc_channel_classifier.sv
// RC channel classifier: a sample (channel, pulse value) is registered, classified by
// the mode that the mode map holds for its channel, and the result word is registered.
// One word enters per cycle while the output is not stalled. Per-channel press, toggle
// and level bits sit in flip-flops that are read and written in the classify stage, so
// back-to-back words on one channel need no bubble. Configuration writes are always
// ready and take effect on the next cycle.
// Depends on rcc_pkg, rcc_cfg_regs and rcc_classify.
`timescale 1ns / 1ps

module rc_channel_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rcc_pkg::in_word_t             in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rcc_pkg::res_word_t            out_word_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rcc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rcc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import rcc_pkg::*;

  cfg_t      cfg;
  logic      in_valid_q;
  in_word_t  in_word_q;
  logic      out_valid_q;
  res_word_t out_word_q;
  res_word_t res;
  logic      advance;

  rcc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  rcc_classify u_classify (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .upd_en_i (in_valid_q && advance),
    .word_i   (in_word_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (advance) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) in_word_q <= in_word_i;
    if (advance && in_valid_q) out_word_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// File: hw/rtl/rcc_checker.sv
// Port-level checker for the classifier and its bind to the top level.
// Depends on rcc_pkg and rc_channel_classifier_macros.svh.
`timescale 1ns / 1ps
`include "rc_channel_classifier_macros.svh"

module rcc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_i,
  input rcc_pkg::in_word_t             in_word_i,
  input logic                          out_valid_i,
  input logic                          out_stall_i,
  input rcc_pkg::res_word_t            out_word_i
);
  import rcc_pkg::*;

  `RCC_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && in_stall_i, in_valid_i && $stable(in_word_i))
  `RCC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(out_word_i))
  `RCC_ASSERT_IMPL(a_push_mode, clk_i, rst_ni, out_valid_i && out_word_i.push_event, out_word_i.mode_used == MODE_PUSH)
  `RCC_ASSERT_IMPL(a_switch_mode, clk_i, rst_ni, out_valid_i && (out_word_i.switch_position != SwPos1), out_word_i.mode_used == MODE_SWITCH)
  `RCC_ASSERT_IMPL(a_range_mode, clk_i, rst_ni, out_valid_i && (out_word_i.channel_out >= ChW'(NumChannels)), (out_word_i.mode_used == MODE_NONE) && !out_word_i.toggle_on && (out_word_i.throttle_level == LevelUnset))

endmodule

bind rc_channel_classifier rcc_checker u_rcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_i  (out_word_o)
);

// File: tb/tb_rc_channel_classifier.sv
// Self-checking testbench of rc_channel_classifier: directed and random samples,
// random input gaps and output stalls, and checks against an in-bench predictor.
// Depends on rcc_pkg and the rc_channel_classifier RTL.
`timescale 1ns / 1ps

module tb_rc_channel_classifier;
  import rcc_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned HoldCycles = 64;
  localparam int unsigned DrainSlack = 8;
  localparam logic [ModeW-1:0] ModeSpare6 = 3'd6;
  localparam logic [ModeW-1:0] ModeSpare7 = 3'd7;
  localparam logic [CfgIdxW-1:0] CfgUnused = CfgIdxW'(2);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  res_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // predictor state
  logic [ModeMapW-1:0] map_q;
  logic [DeadBandW-1:0] db_q;
  logic press_q [NumChannels];
  logic toggle_q [NumChannels];
  logic [1:0] level_q [NumChannels];
  res_word_t expected_results [$];

  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned cfg_writes = 0;
  int unsigned cycles = 0;
  int unsigned tx_run_left = 0;
  int unsigned rx_stall_left = 0;
  int unsigned rx_run_left = 0;
  logic gaps_on = 1'b1;
  logic hold_on = 1'b0;
  event hold_go;

  rc_channel_classifier uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) cycles <= cycles + 1;

  initial begin
    while (cycles < CycleLimit) @(posedge clk_i);
    $display("** rc_channel_classifier: FAILED **");
    $finish;
  end

  function automatic res_word_t classify_sample(in_word_t w);
    res_word_t r;
    logic [ChW-1:0] ch;
    logic [ValW-1:0] v;
    logic [ValW-1:0] delta;
    logic [ModeW-1:0] m;
    logic pressed;
    r = '0;
    ch = w.channel;
    v = w.pulse_value;
    if (ch < NumChannels) begin
      m = map_q[3*ch +: 3];
      r.mode_used = m;
      pressed = (v > ValCenter);
      case (m)
        MODE_DEADBAND: begin
          delta = (v > ValCenter) ? v - ValCenter : ValCenter - v;
          if (delta < ValW'(db_q)) v = ValCenter;
        end
        MODE_LEVEL: begin
          if (v > ValLevelMin && v <= ValLevelNull) level_q[ch] = LevelNull;
          else if (v > ValLevelNull && v <= ValLevelLow) level_q[ch] = LevelLow;
          else if (v > ValLevelLow && v < ValLevelMax) level_q[ch] = LevelHigh;
        end
        MODE_TOGGLE: begin
          if (pressed && !press_q[ch]) toggle_q[ch] = !toggle_q[ch];
          press_q[ch] = pressed;
        end
        MODE_PUSH: begin
          r.push_event = pressed && !press_q[ch];
          press_q[ch] = pressed;
        end
        MODE_SWITCH: begin
          if (v < ValSwitchLo) r.switch_position = SwPos1;
          else if (v > ValSwitchLo && v < ValSwitchHi) r.switch_position = SwPos2;
          else if (v > ValSwitchHi) r.switch_position = SwPos3;
          else r.switch_position = SwError;
        end
        MODE_NONE: ;
        default: r.mode_used = MODE_NONE;
      endcase
      r.throttle_level = level_q[ch];
      r.toggle_on = toggle_q[ch];
    end
    r.channel_out = ch;
    r.value_out = v;
    return r;
  endfunction

  function automatic string fmt_res(res_word_t r);
    return $sformatf("ch=%0d val=%0d mode=%0d lvl=%0d sw=%0d tog=%0b push=%0b",
                     r.channel_out, r.value_out, r.mode_used, r.throttle_level,
                     r.switch_position, r.toggle_on, r.push_event);
  endfunction

  task automatic check_result(res_word_t got);
    res_word_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word: %s", fmt_res(got));
    end else begin
      want = expected_results.pop_front();
      if (got.channel_out !== want.channel_out || got.value_out !== want.value_out ||
          got.mode_used !== want.mode_used || got.throttle_level !== want.throttle_level ||
          got.switch_position !== want.switch_position ||
          got.toggle_on !== want.toggle_on || got.push_event !== want.push_event) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch on result %0d", results_checked);
          $display("  expected %s", fmt_res(want));
          $display("  actual   %s", fmt_res(got));
        end
      end
      results_checked++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid === 1'b1 && !out_stall) check_result(out_word);
  end

  // receiver stall bursts; a long hold overrides them
  always @(posedge clk_i) begin
    if (hold_on) begin
      out_stall <= 1'b1;
    end else if (rx_stall_left != 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_stall <= 1'b1;
    end else if (rx_run_left != 0) begin
      rx_run_left <= rx_run_left - 1;
      out_stall <= 1'b0;
    end else if (gaps_on) begin
      rx_stall_left <= $urandom_range(0, 10);
      rx_run_left <= $urandom_range(0, 30);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always begin
    @(hold_go);
    hold_on <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  // leaves valid high so a following word goes out back to back
  task automatic send_word(in_word_t w);
    in_valid <= 1'b1;
    in_word <= w;
    forever begin
      @(posedge clk_i);
      if (!in_stall) break;
    end
    expected_results.push_back(classify_sample(w));
    words_sent++;
  endtask

  task automatic offer(logic [ChW-1:0] ch, logic [ValW-1:0] v);
    in_word_t w;
    w.channel = ch;
    w.pulse_value = v;
    send_word(w);
    if (!gaps_on) return;
    if (tx_run_left != 0) begin
      tx_run_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
      tx_run_left = $urandom_range(0, 25);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready) break;
    end
    if (idx == CfgModeMap) map_q = data[ModeMapW-1:0];
    else if (idx == CfgDeadBand) db_q = data[DeadBandW-1:0];
    cfg_writes++;
  endtask

  // only called once the block is idle
  task automatic configure(logic [ModeMapW-1:0] map, logic [DeadBandW-1:0] db);
    drain();
    write_reg(CfgModeMap, CfgDataW'(map));
    write_reg(CfgDeadBand, {22'($urandom), db});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [ChW-1:0] rand_channel();
    if ($urandom_range(0, 7) == 0) return ChW'($urandom_range(NumChannels, 15));
    return ChW'($urandom_range(0, NumChannels - 1));
  endfunction

  function automatic logic [ValW-1:0] rand_value();
    int unsigned pick;
    logic [ValW-1:0] base;
    pick = $urandom_range(0, 9);
    if (pick == 0) return ValW'($urandom_range(0, 4095));
    if (pick <= 3) begin
      case ($urandom_range(0, 7))
        0: base = ValLevelMin;
        1: base = ValLevelNull;
        2: base = ValLevelLow;
        3: base = ValLevelMax;
        4: base = ValSwitchLo;
        5: base = ValSwitchHi;
        6: base = ValCenter + ValW'(db_q);
        default: base = ValCenter - ValW'(db_q);
      endcase
      return base + ValW'($urandom_range(0, 4)) - ValW'(2);
    end
    return ValW'($urandom_range(950, 2050));
  endfunction

  // mix of single words and runs on one channel, so press edges and levels chain up
  task automatic run_random(int unsigned n);
    int unsigned sent;
    int unsigned len;
    logic [ChW-1:0] ch;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 1) == 1) begin
        ch = rand_channel();
        len = $urandom_range(2, 8);
        repeat (len) offer(ch, rand_value());
        sent += len;
      end else begin
        offer(rand_channel(), rand_value());
        sent++;
      end
    end
  endtask

  task automatic test_reset_defaults();
    for (int c = 0; c < NumChannels; c++) offer(ChW'(c), ValW'(1800));
  endtask

  task automatic test_directed();
    logic [ModeMapW-1:0] map;
    map = {MODE_SWITCH, MODE_DEADBAND, ModeSpare7, ModeSpare6, MODE_SWITCH,
           MODE_PUSH, MODE_TOGGLE, MODE_LEVEL, MODE_DEADBAND, MODE_NONE};
    configure(map, 8'd0);
    offer(4'd1, ValCenter);
    configure(map, 8'd255);
    @(posedge clk_i);
    write_reg(CfgUnused, CfgDataW'($urandom));
    cfg_valid <= 1'b0;
    offer(4'd1, ValW'(1245));
    offer(4'd1, ValW'(1246));
    offer(4'd1, ValW'(1754));
    offer(4'd8, ValW'(0));
    offer(4'd8, ValW'(4095));
    offer(4'd2, ValLevelMin);
    offer(4'd2, ValLevelMin + ValW'(1));
    offer(4'd2, ValLevelNull + ValW'(1));
    offer(4'd2, ValLevelLow + ValW'(1));
    offer(4'd2, ValLevelMax);
    offer(4'd2, ValLevelLow);
    offer(4'd5, ValSwitchLo - ValW'(1));
    offer(4'd5, ValSwitchLo);
    offer(4'd5, ValSwitchLo + ValW'(1));
    offer(4'd9, ValSwitchHi);
    offer(4'd9, ValSwitchHi + ValW'(1));
    offer(4'd3, ValCenter + ValW'(1));
    offer(4'd3, ValCenter + ValW'(1));
    offer(4'd3, ValCenter);
    offer(4'd3, ValW'(4095));
    offer(4'd4, ValCenter + ValW'(1));
    offer(4'd4, ValW'(0));
    offer(4'd4, ValCenter + ValW'(1));
    offer(4'd6, ValW'(1800));
    offer(4'd7, ValW'(1800));
    offer(4'd0, ValW'(4095));
    offer(4'd10, ValW'(1800));
    offer(4'd15, ValW'(4095));
    // press left set by toggle must block the push edge
    map[3*3 +: 3] = MODE_PUSH;
    configure(map, 8'd255);
    offer(4'd3, ValW'(1800));
  endtask

  task automatic test_random_phases();
    configure('0, 8'd0);
    run_random(100);
    configure('1, 8'd255);
    run_random(100);
    for (int p = 0; p < 7; p++) begin
      configure(ModeMapW'($urandom), (p % 3 == 0) ? 8'd255 : 8'($urandom));
      run_random(200);
    end
  endtask

  task automatic test_backpressure();
    in_word_t w;
    configure(ModeMapW'($urandom), 8'($urandom));
    -> hold_go;
    repeat (60) begin
      w.channel = rand_channel();
      w.pulse_value = rand_value();
      send_word(w);
    end
  endtask

  task automatic test_pause();
    run_random(20);
    drain();
    run_random(20);
  endtask

  task automatic test_no_gaps();
    gaps_on <= 1'b0;
    configure(ModeMapW'($urandom), 8'($urandom));
    run_random(200);
  endtask

  initial begin
    map_q = ModeMapReset;
    db_q = DeadBandReset;
    for (int c = 0; c < NumChannels; c++) begin
      press_q[c] = 1'b0;
      toggle_q[c] = 1'b0;
      level_q[c] = LevelUnset;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_directed();
    test_random_phases();
    test_backpressure();
    test_pause();
    test_no_gaps();
    drain();
    repeat (DrainSlack) @(posedge clk_i);
    $display("%0d sample words over %0d register writes, %0d result words checked",
             words_sent, cfg_writes, results_checked);
    $display("all modes, band edges, stall bursts, long output hold; %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("** rc_channel_classifier: PASSED **");
    end else begin
      $display("** rc_channel_classifier: FAILED **");
    end
    $finish;
  end

endmodule
